@@ rtl/nrb_pkg.sv @@
package nrb_pkg;

  // fixed field width of the root degree
  localparam int unsigned DegreeW = 6;

  // defaults for the top-level parameters
  localparam int unsigned RadicandBitsDef = 32;
  localparam int unsigned FractionBitsDef = 20;
  localparam int unsigned MaxDegreeDef    = 63;

  // partial products of one split multiply
  localparam int unsigned PpCount = 4;

  // which halves of the operands feed the multiplier
  typedef enum logic [1:0] {
    PP_LL = 2'd0,
    PP_LH = 2'd1,
    PP_HL = 2'd2,
    PP_HH = 2'd3
  } pp_sel_e;

  typedef struct packed {
    logic    load;
    logic    step;
    logic    pp_en;
    pp_sel_e pp_sel;
    logic    add_en;
    logic    add_first;
    pp_sel_e add_sel;
    logic    acc_load;
    logic    set_low;
    logic    set_high;
    logic    out_load;
  } nrb_cmd_t;

  typedef struct packed {
    logic is_tiny;
    logic interval_done;
    logic over;
    logic below;
  } nrb_status_t;

endpackage

@@ rtl/nrb_dpath.sv @@
module nrb_dpath import nrb_pkg::*; #(
  parameter int unsigned RadicandBits = RadicandBitsDef,
  parameter int unsigned FractionBits = FractionBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  nrb_cmd_t                             cmd_i,
  input  logic [RadicandBits-1:0]              radicand_i,
  output nrb_status_t                          status_o,
  output logic [RadicandBits+FractionBits-1:0] root_o
);

  localparam int unsigned W   = RadicandBits + FractionBits;
  localparam int unsigned H   = (W + 1) / 2;
  localparam int unsigned PPW = 2 * H;
  localparam int unsigned PW  = 4 * H;

  logic [W-1:0]   target_q, low_q, high_q, mid_q, acc_q, root_q;
  logic           tiny_q;
  logic [PPW-1:0] pp_q;
  logic [PW-1:0]  prod_q;

  logic [W-1:0]   one_fx;
  logic [W-1:0]   span;
  logic [W-1:0]   mid_d;
  logic [PPW-1:0] a_ext, b_ext;
  logic [H-1:0]   op_a, op_b;
  logic [PPW-1:0] pp_d;
  logic [PW-1:0]  pp_ext, pp_shifted, prod_d;
  logic [PW-1:0]  quot;

  assign one_fx = W'(1) << FractionBits;
  assign span   = high_q - low_q;
  assign mid_d  = low_q + (span >> 1);

  // operand halves, acc times mid
  assign a_ext = PPW'(acc_q);
  assign b_ext = PPW'(mid_q);

  always_comb begin
    unique case (cmd_i.pp_sel)
      PP_LL: begin
        op_a = a_ext[H-1:0];
        op_b = b_ext[H-1:0];
      end
      PP_LH: begin
        op_a = a_ext[H-1:0];
        op_b = b_ext[PPW-1:H];
      end
      PP_HL: begin
        op_a = a_ext[PPW-1:H];
        op_b = b_ext[H-1:0];
      end
      default: begin
        op_a = a_ext[PPW-1:H];
        op_b = b_ext[PPW-1:H];
      end
    endcase
  end

  assign pp_d   = PPW'(op_a) * PPW'(op_b);
  assign pp_ext = PW'(pp_q);

  always_comb begin
    unique case (cmd_i.add_sel) inside
      PP_LL:        pp_shifted = pp_ext;
      PP_LH, PP_HL: pp_shifted = pp_ext << H;
      default:      pp_shifted = pp_ext << PPW;
    endcase
  end

  assign prod_d = cmd_i.add_first ? pp_shifted : prod_q + pp_shifted;

  // truncated fixed-point product
  assign quot = prod_q >> FractionBits;

  assign status_o.is_tiny       = tiny_q;
  assign status_o.interval_done = span <= W'(1);
  assign status_o.over          = quot > PW'(target_q);
  assign status_o.below         = acc_q < target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiny_q <= 1'b0;
    end else if (cmd_i.load) begin
      tiny_q <= (radicand_i[RadicandBits-1:1] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q <= W'(radicand_i) << FractionBits;
      high_q   <= W'(radicand_i) << FractionBits;
      low_q    <= one_fx;
    end
    if (cmd_i.step) begin
      mid_q <= mid_d;
      acc_q <= one_fx;
    end
    if (cmd_i.pp_en) begin
      pp_q <= pp_d;
    end
    if (cmd_i.add_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_q[FractionBits +: W];
    end
    if (cmd_i.set_low) begin
      low_q <= mid_q;
    end
    if (cmd_i.set_high) begin
      high_q <= mid_q;
    end
    if (cmd_i.out_load) begin
      root_q <= high_q;
    end
  end

  assign root_o = root_q;

endmodule

@@ rtl/nrb_ctrl.sv @@
module nrb_ctrl import nrb_pkg::*; #(
  parameter int unsigned MaxDegree = MaxDegreeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [DegreeW-1:0] degree_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  nrb_status_t        status_i,
  output nrb_cmd_t           cmd_o
);

  localparam int unsigned CntW = $clog2(PpCount + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL,
    ST_TEST,
    ST_FINAL,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [DegreeW-1:0] deg_q, iter_q, deg_d;
  logic [CntW-1:0]   pp_cnt_q;
  logic              out_valid_q;
  logic              finished;
  logic [1:0]        add_idx;

  assign deg_d    = (degree_i > DegreeW'(MaxDegree)) ? DegreeW'(MaxDegree) : degree_i;
  assign finished = status_i.is_tiny | status_i.interval_done;
  assign add_idx  = pp_cnt_q[1:0] - 2'd1;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      ST_STEP: begin
        cmd_o.step = !finished;
      end
      ST_MUL: begin
        // issue the next partial product while one remains, fold in the previous one once there is one
        cmd_o.pp_en     = (pp_cnt_q < CntW'(PpCount));
        cmd_o.pp_sel    = pp_sel_e'(pp_cnt_q[1:0]);
        cmd_o.add_en    = (pp_cnt_q != '0);
        cmd_o.add_first = (pp_cnt_q == CntW'(1));
        cmd_o.add_sel   = pp_sel_e'(add_idx);
      end
      ST_TEST: begin
        cmd_o.set_high = status_i.over;
        cmd_o.acc_load = !status_i.over;
      end
      ST_FINAL: begin
        cmd_o.set_low  = status_i.below;
        cmd_o.set_high = !status_i.below;
      end
      ST_DONE: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      deg_q       <= '0;
      iter_q      <= '0;
      pp_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            deg_q   <= deg_d;
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          iter_q   <= '0;
          pp_cnt_q <= '0;
          if (finished) begin
            state_q <= ST_DONE;
          end else if (deg_q == '0) begin
            state_q <= ST_FINAL;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          pp_cnt_q <= pp_cnt_q + CntW'(1);
          if (pp_cnt_q == CntW'(PpCount)) begin
            state_q <= ST_TEST;
          end
        end
        ST_TEST: begin
          pp_cnt_q <= '0;
          if (status_i.over) begin
            state_q <= ST_STEP;
          end else if (iter_q + DegreeW'(1) == deg_q) begin
            state_q <= ST_FINAL;
          end else begin
            iter_q  <= iter_q + DegreeW'(1);
            state_q <= ST_MUL;
          end
        end
        ST_FINAL: begin
          state_q <= ST_STEP;
        end
        ST_DONE: begin
          if (cmd_o.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/nth_root_bisection_unit.sv @@
// sequence: load, then per bisection step a midpoint step and up to degree multiplies of the
// running power by the midpoint, each followed by a compare; a step is cut short by a partial
// power above the target, else a final compare moves one bound (about 52 steps at default widths)
// throughput: one transaction at a time; each multiply runs on the shared half-width multiplier
// as four partial products, one drain and one compare
// reset: asynchronous active-low, clears the controller and the output valid; no clearing pass
module nth_root_bisection_unit import nrb_pkg::*; #(
  parameter int unsigned RADICAND_BITS = RadicandBitsDef,
  parameter int unsigned FRACTION_BITS = FractionBitsDef,
  parameter int unsigned MAX_DEGREE    = MaxDegreeDef
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // degree [DegreeW-1:0], radicand above it, zero pad to whole bytes
  input  logic [((DegreeW+RADICAND_BITS+7)/8)*8-1:0] s_axis_tdata_i,

  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // root (unsigned fixed point, FRACTION_BITS fraction bits), zero pad to whole bytes
  output logic [((RADICAND_BITS+FRACTION_BITS+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned RootW     = RADICAND_BITS + FRACTION_BITS;
  localparam int unsigned OutTdataW = ((RootW + 7) / 8) * 8;

  nrb_cmd_t                 cmd;
  nrb_status_t              status;
  logic [DegreeW-1:0]       degree;
  logic [RADICAND_BITS-1:0] radicand;
  logic [RootW-1:0]         root;

  // unpack the input transaction
  assign degree   = s_axis_tdata_i[DegreeW-1:0];
  assign radicand = s_axis_tdata_i[DegreeW +: RADICAND_BITS];

  // controller: bisection sequencing, power loop count, partial product order
  nrb_ctrl #(
    .MaxDegree (MAX_DEGREE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .degree_i    (degree),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: interval bounds, midpoint, running power and split multiplier
  nrb_dpath #(
    .RadicandBits (RADICAND_BITS),
    .FractionBits (FRACTION_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .radicand_i (radicand),
    .status_o   (status),
    .root_o     (root)
  );

  // result register sits in the datapath, so the next transaction may start
  // while this one is still waiting downstream
  assign m_axis_tdata_o = OutTdataW'(root);

endmodule
